// ===== rtl/sfms_pkg.sv =====
// ----------------------------------------------------------------------------
// sfms_pkg
// Shared constants and types of the streaming first-match substring search.
// ----------------------------------------------------------------------------
package sfms_pkg;

  localparam int MAX_PATTERN   = 16;
  localparam int POSITION_BITS = 16;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 5;
  localparam int POS_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  localparam int CNT_W       = POSITION_BITS + 1;
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int LHIT_IDX_W  = $clog2(MAX_PATTERN + 1);
  localparam int PAT_STORE_W = 2 * CFG_DATA_W;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 8'd0,
    REG_PATTERN_HIGH = 8'd1,
    REG_PATTERN_LEN  = 8'd2,
    REG_START_POS    = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    byte_t [MAX_PATTERN-1:0] pattern;
    logic [LEN_W-1:0]        length;
    logic [POS_W-1:0]        start;
  } search_cfg_t;

endpackage

// ===== rtl/sfms_if.sv =====
// ----------------------------------------------------------------------------
// sfms_if
// Valid/ready channels of the substring search: text, result, register write.
// ----------------------------------------------------------------------------
interface sfms_text_if;
  logic                        valid;
  logic                        ready;
  logic [sfms_pkg::BYTE_W-1:0] text_byte;
  logic                        last_byte;

  modport source (output valid, text_byte, last_byte, input ready);
  modport sink   (input valid, text_byte, last_byte, output ready);
endinterface

interface sfms_result_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [sfms_pkg::POS_W-1:0] match_position;

  modport source (output valid, found, match_position, input ready);
  modport sink   (input valid, found, match_position, output ready);
endinterface

interface sfms_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sfms_pkg::CFG_IDX_W-1:0]  index;
  logic [sfms_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/substring_first_match_search.sv =====
// ----------------------------------------------------------------------------
// substring_first_match_search
// Streaming first-match search of a configured pattern in byte strings.
//
//   channel    dir  payload                         transaction
//   cfg_wr     in   index[7:0], data[63:0]          register write
//   text_in    in   text_byte[7:0], last_byte       one text byte
//   result_out out  found, match_position[15:0]     one result per string
//
// One byte per cycle while no last byte stalls: a byte is registered, then the
// window shift and the full parallel window compare work on that register.
// A result is registered when its last byte leaves the input register.
// Reset clears the settings, the per-string state and both valid flags.
// Only a last byte stalls, when the result register is still full.
// ----------------------------------------------------------------------------
module substring_first_match_search (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sfms_cfg_if.sink             cfg_wr,
  sfms_text_if.sink            text_in,
  sfms_result_if.source        result_out
);
  import sfms_pkg::*;

  logic [CFG_DATA_W-1:0] pat_lo_q, pat_hi_q;
  logic [LEN_W-1:0]      len_q;
  logic [POS_W-1:0]      start_q;
  logic [PAT_STORE_W-1:0] pat_all;
  search_cfg_t           cfg;

  logic                  s1_valid_q, s1_last_q;
  byte_t                 s1_byte_q;
  logic                  in_fire, s1_fire, slot_free;

  byte_t [MAX_PATTERN-1:0] window_q, window_sh, window_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d, cnt_plus;
  logic                  have_q, have_d;
  logic [POS_W-1:0]      off_q, off_d;
  logic                  win_match, active, hit;
  logic [CMP_W-1:0]      start_ext;

  logic                  out_valid_q, found_q;
  logic [POS_W-1:0]      pos_q;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= '0;
      start_q  <= '0;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      case (cfg_reg_e'(cfg_wr.index))
        REG_PATTERN_LOW:  pat_lo_q <= cfg_wr.data;
        REG_PATTERN_HIGH: pat_hi_q <= cfg_wr.data;
        REG_PATTERN_LEN:  len_q    <= cfg_wr.data[LEN_W-1:0];
        REG_START_POS:    start_q  <= cfg_wr.data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_all = {pat_hi_q, pat_lo_q};

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      cfg.pattern[k] = pat_all[k*BYTE_W +: BYTE_W];
    end
    cfg.length = len_q;
    cfg.start  = start_q;
  end

  assign slot_free     = !out_valid_q || result_out.ready;
  assign s1_fire       = s1_valid_q && (!s1_last_q || slot_free);
  assign text_in.ready = !s1_valid_q || s1_fire;
  assign in_fire       = text_in.valid && text_in.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= text_in.text_byte;
      s1_last_q <= text_in.last_byte;
    end
  end

  always_comb begin
    window_sh[0] = s1_byte_q;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      window_sh[i] = window_q[i-1];
    end
  end

  sfms_matcher u_matcher (
    .window_i (window_sh),
    .cfg_i    (cfg),
    .match_o  (win_match)
  );

  assign active    = !cnt_q[CNT_W-1];
  assign cnt_plus  = cnt_q + CNT_W'(1);
  assign start_ext = CMP_W'(cnt_plus) - CMP_W'(len_q);
  assign hit       = active && !have_q && win_match
                  && (CMP_W'(cnt_plus) >= CMP_W'(len_q))
                  && (start_ext >= CMP_W'(start_q));

  always_comb begin
    window_d = window_q;
    cnt_d    = cnt_q;
    have_d   = have_q;
    off_d    = off_q;
    if (s1_fire) begin
      if (s1_last_q) begin
        window_d = '0;
        cnt_d    = '0;
        have_d   = 1'b0;
        off_d    = '0;
      end else begin
        window_d = window_sh;
        if (active) begin
          cnt_d = cnt_plus;
        end
        if (hit) begin
          have_d = 1'b1;
          off_d  = start_ext[POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      cnt_q    <= '0;
      have_q   <= 1'b0;
      off_q    <= '0;
    end else begin
      window_q <= window_d;
      cnt_q    <= cnt_d;
      have_q   <= have_d;
      off_q    <= off_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (result_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      found_q <= have_q || hit;
      pos_q   <= have_q ? off_q : (hit ? start_ext[POS_W-1:0] : '0);
    end
  end

  assign result_out.valid          = out_valid_q;
  assign result_out.found          = found_q;
  assign result_out.match_position = pos_q;

  a_no_pos_without_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (pos_q == '0))
    else $error("match_position nonzero without a match");

  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cnt_q[CNT_W-1] || (cnt_q[CNT_W-2:0] == '0))
    else $error("byte count passed its limit");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |=> ((cnt_q == '0) && !have_q))
    else $error("string state not cleared after last byte");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_fire && s1_last_q))
    else $error("result raised without a last byte");

endmodule

// ===== rtl/sfms_matcher.sv =====
// ----------------------------------------------------------------------------
// sfms_matcher
// Parallel compare of the byte window against the pattern at its length.
// ----------------------------------------------------------------------------
module sfms_matcher (
  input  sfms_pkg::byte_t [sfms_pkg::MAX_PATTERN-1:0] window_i,
  input  sfms_pkg::search_cfg_t                        cfg_i,
  output logic                                         match_o
);
  import sfms_pkg::*;

  logic [MAX_PATTERN:0] len_hit;

  always_comb begin
    len_hit = '0;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      len_hit[l] = 1'b1;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        if (k < l) begin
          if (cfg_i.pattern[k] != window_i[l-1-k]) begin
            len_hit[l] = 1'b0;
          end
        end
      end
    end
  end

  assign match_o = (cfg_i.length <= LEN_W'(MAX_PATTERN))
                 ? len_hit[cfg_i.length[LHIT_IDX_W-1:0]] : 1'b0;

endmodule

// ===== bench/tb_substring_first_match_search.sv =====
// ----------------------------------------------------------------------------
// tb_substring_first_match_search
// Self-checking bench for the streaming first-match substring search.
// A directed table covers reset state, empty and overlong patterns, short
// strings, a match on the final byte and a start offset past the text.
// Random phases then reprogram the search and stream strings built around
// the pattern, intact or broken, plus noise. Every result is compared with
// the table's expected result or with a local predictor.
// ----------------------------------------------------------------------------
module tb_substring_first_match_search;
  import sfms_pkg::*;

  localparam int          CLK_HALF      = 5;
  localparam int          RESET_CYCLES  = 12;
  localparam int          RANDOM_ITEMS  = 1900;
  localparam int          DRAIN_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned COUNT_LIMIT   = 1 << POSITION_BITS;
  localparam int          BUF_DEPTH     = 128;
  localparam int          DIRECTED_ROWS = 26;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } search_result_t;

  typedef enum logic {ROW_CFG, ROW_TEXT} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [LEN_W-1:0]      len;
    logic [POS_W-1:0]      start;
    byte_t                 text;
    logic                  last;
    logic                  typed;
    logic                  found;
    logic [POS_W-1:0]      pos;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sfms_cfg_if    cfg_bus ();
  sfms_text_if   text_bus ();
  sfms_result_if result_bus ();

  substring_first_match_search u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_wr     (cfg_bus),
    .text_in    (text_bus),
    .result_out (result_bus)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // search settings as last written
  byte_t            pat_shadow [MAX_PATTERN];
  logic [LEN_W-1:0] pat_len;
  logic [POS_W-1:0] start_pos;

  // per-string scan state
  byte_t            history [MAX_PATTERN];
  int unsigned      seen_count;
  bit               hit_seen;
  logic [POS_W-1:0] hit_offset;

  search_result_t pending_results [$];

  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned text_count;
  int unsigned string_count;
  int unsigned setting_count;
  int unsigned result_count;
  int unsigned match_count;

  directed_row_t directed_rows [DIRECTED_ROWS];

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH at cycle %0d: %s got %0d expected %0d",
             cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic restart_string();
    for (int k = 0; k < MAX_PATTERN; k++) history[k] = '0;
    seen_count = 0;
    hit_seen   = 1'b0;
    hit_offset = '0;
  endtask

  task automatic scan_text_byte(input byte_t b, input logic last, output bit produced,
                                output search_result_t res);
    int unsigned st;
    bit          ok;
    for (int k = MAX_PATTERN - 1; k > 0; k--) history[k] = history[k-1];
    history[0] = b;
    if (seen_count < COUNT_LIMIT) begin
      if (!hit_seen && pat_len != 0 && pat_len <= MAX_PATTERN &&
          seen_count + 1 >= pat_len) begin
        st = seen_count + 1 - pat_len;
        if (st >= start_pos) begin
          ok = 1'b1;
          for (int k = 0; k < pat_len; k++) begin
            if (pat_shadow[k] != history[pat_len - 1 - k]) ok = 1'b0;
          end
          if (ok) begin
            hit_seen   = 1'b1;
            hit_offset = st[POS_W-1:0];
          end
        end
      end
      seen_count++;
    end
    produced  = last;
    res.found = hit_seen;
    res.pos   = hit_seen ? hit_offset : '0;
    if (last) restart_string();
  endtask

  function automatic int tx_gap();
    return tx_idle_on ? $urandom_range(0, 10) : 0;
  endfunction

  task automatic send_text(input byte_t b, input logic last, input int gap,
                           input bit typed, input search_result_t typed_res);
    bit             produced;
    search_result_t res;
    if (gap != 0) begin
      text_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    text_bus.valid     <= 1'b1;
    text_bus.text_byte <= b;
    text_bus.last_byte <= last;
    do @(posedge clk_i); while (!text_bus.ready);
    scan_text_byte(b, last, produced, res);
    text_count++;
    if (produced) begin
      pending_results.push_back(typed ? typed_res : res);
      string_count++;
    end
  endtask

  task automatic wait_drained();
    text_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_search(input logic [CFG_DATA_W-1:0] lo, hi, len_word, start_word,
                                input bit with_unused);
    cfg_reg_e              order [4];
    cfg_reg_e              idx;
    logic [CFG_DATA_W-1:0] d;
    int                    first;
    int                    unused_idx;
    order = '{REG_PATTERN_LOW, REG_PATTERN_HIGH, REG_PATTERN_LEN, REG_START_POS};
    first = $urandom_range(0, 3);
    for (int n = 0; n < 4; n++) begin
      idx = order[(first + n) % 4];
      case (idx)
        REG_PATTERN_LOW:  d = lo;
        REG_PATTERN_HIGH: d = hi;
        REG_PATTERN_LEN:  d = len_word;
        default:          d = start_word;
      endcase
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx;
      cfg_bus.data  <= d;
      do @(posedge clk_i); while (!cfg_bus.ready);
      case (idx)
        REG_PATTERN_LOW:  for (int k = 0; k < 8; k++) pat_shadow[k] = d[8*k +: 8];
        REG_PATTERN_HIGH: for (int k = 0; k < 8; k++) pat_shadow[8+k] = d[8*k +: 8];
        REG_PATTERN_LEN:  pat_len = d[LEN_W-1:0];
        default:          start_pos = d[POS_W-1:0];
      endcase
    end
    if (with_unused) begin
      unused_idx = $urandom_range(int'(REG_START_POS) + 1, (1 << CFG_IDX_W) - 1);
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= CFG_IDX_W'(unused_idx);
      cfg_bus.data  <= {$urandom(), $urandom()};
      do @(posedge clk_i); while (!cfg_bus.ready);
    end
    cfg_bus.valid <= 1'b0;
    setting_count++;
  endtask

  task automatic run_search_phase(input int phase);
    byte_t                 alpha [3];
    byte_t                 pat [MAX_PATTERN];
    byte_t                 text_buf [BUF_DEPTH];
    logic [CFG_DATA_W-1:0] lo, hi, len_word, start_word;
    int                    plen, pstart, n_str, str_len, ins;
    bit                    full_random, noise;
    if (phase == 0) plen = MAX_PATTERN;
    else if (phase == 2) plen = 0;
    else begin
      case ($urandom_range(0, 9))
        0:       plen = $urandom_range(MAX_PATTERN + 1, (1 << LEN_W) - 1);
        1:       plen = MAX_PATTERN;
        2:       plen = 0;
        default: plen = $urandom_range(1, MAX_PATTERN);
      endcase
    end
    if (phase == 1) pstart = (1 << POS_W) - 1;
    else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: pstart = 0;
        5, 6, 7:       pstart = $urandom_range(0, 24);
        8:             pstart = (1 << POS_W) - 1;
        default:       pstart = $urandom_range(0, (1 << POS_W) - 1);
      endcase
    end
    for (int i = 0; i < 3; i++) alpha[i] = byte_t'($urandom());
    full_random = ($urandom_range(0, 4) == 0);
    for (int k = 0; k < MAX_PATTERN; k++)
      pat[k] = (k < plen) ? alpha[$urandom_range(0, 2)] : byte_t'($urandom());
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = pat[k];
      hi[8*k +: 8] = pat[8+k];
    end
    len_word   = $urandom_range(0, 1) ? {$urandom(), $urandom()} : '0;
    start_word = $urandom_range(0, 1) ? {$urandom(), $urandom()} : '0;
    len_word[LEN_W-1:0]   = LEN_W'(plen);
    start_word[POS_W-1:0] = POS_W'(pstart);

    wait_drained();
    program_search(lo, hi, len_word, start_word, $urandom_range(0, 2) == 0);
    tx_idle_on = ($urandom_range(0, 3) != 0);
    rx_idle_on = ($urandom_range(0, 3) != 0);

    n_str = $urandom_range(4, 12);
    for (int s = 0; s < n_str; s++) begin
      if ($urandom_range(0, 7) == 0) wait_drained();
      str_len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 100) : $urandom_range(1, 40);
      noise   = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < str_len; k++)
        text_buf[k] = (noise || full_random) ? byte_t'($urandom()) : alpha[$urandom_range(0, 2)];
      if (!noise && plen >= 1 && plen <= MAX_PATTERN && plen <= str_len &&
          $urandom_range(0, 9) < 7) begin
        ins = $urandom_range(0, str_len - plen);
        for (int k = 0; k < plen; k++) text_buf[ins + k] = pat[k];
        if ($urandom_range(0, 3) == 0)
          text_buf[ins + $urandom_range(0, plen - 1)] ^= byte_t'(1 << $urandom_range(0, 7));
      end
      for (int k = 0; k < str_len; k++)
        send_text(text_buf[k], k == str_len - 1, tx_gap(), 1'b0, '0);
    end
  endtask

  // result receiver: when idle insertion is on, hold ready low for a random gap before each transaction
  initial begin
    int gap;
    result_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 10) : 0;
      if (gap != 0) begin
        result_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(result_bus.valid && result_bus.ready));
    end
  end

  always @(posedge clk_i) begin
    search_result_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      result_count++;
      if (result_bus.found) match_count++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, match_position",
                        result_bus.match_position, 0);
      end else begin
        want = pending_results.pop_front();
        if (result_bus.found !== want.found)
          report_mismatch("found", result_bus.found, want.found);
        if (result_bus.match_position !== want.pos)
          report_mismatch("match_position", result_bus.match_position, want.pos);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending",
               cycle_count, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int            random_base;
    directed_row_t row;
    rst_ni             <= 1'b0;
    text_bus.valid     <= 1'b0;
    text_bus.text_byte <= '0;
    text_bus.last_byte <= 1'b0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= '0;
    cfg_bus.data       <= '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) pat_shadow[k] = '0;
    pat_len   = '0;
    start_pos = '0;
    restart_string();

    directed_rows = '{
      '{ROW_TEXT, '0, '0, '0, '0, 8'h00, 1'b1, 1'b1, 1'b0, 16'd0},
      '{ROW_CFG, {64{1'b1}}, {64{1'b1}}, 5'd1, 16'd0, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'hFF, 1'b1, 1'b1, 1'b1, 16'd0},
      '{ROW_CFG, {64{1'b1}}, {64{1'b1}}, 5'd31, 16'd0, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'hFF, 1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'hFF, 1'b1, 1'b1, 1'b0, 16'd0},
      '{ROW_CFG, 64'h0000_0000_0000_CDAB, 64'd0, 5'd2, 16'd0, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'hAB, 1'b1, 1'b1, 1'b0, 16'd0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'hAB, 1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'hCD, 1'b1, 1'b1, 1'b1, 16'd0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'hAB, 1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'hCD, 1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'hAB, 1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'hCD, 1'b1, 1'b0, 1'b0, 16'd0},
      '{ROW_CFG, 64'h0000_0000_0000_CDAB, 64'd0, 5'd2, 16'd2, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'h00, 1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'hAB, 1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'hCD, 1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'hAB, 1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'hCD, 1'b1, 1'b0, 1'b0, 16'd0},
      '{ROW_CFG, 64'h0000_0000_0000_CDAB, 64'd0, 5'd2, 16'hFFFF, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'hAB, 1'b0, 1'b0, 1'b0, 16'd0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'hCD, 1'b1, 1'b1, 1'b0, 16'd0},
      '{ROW_CFG, 64'd0, 64'd0, 5'd1, 16'd0, '0, 1'b0, 1'b0, 1'b0, '0},
      '{ROW_TEXT, '0, '0, '0, '0, 8'h00, 1'b1, 1'b1, 1'b1, 16'd0}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_CFG) begin
        wait_drained();
        program_search(row.lo, row.hi, CFG_DATA_W'(row.len), CFG_DATA_W'(row.start), 1'b0);
      end else begin
        send_text(row.text, row.last, tx_gap(), row.typed, '{row.found, row.pos});
      end
    end

    random_base = text_count;
    for (int phase = 0; text_count - random_base < RANDOM_ITEMS; phase++)
      run_search_phase(phase);

    wait_drained();

    $display("Streamed %0d text bytes in %0d strings under %0d search settings,",
             text_count, string_count, setting_count);
    $display("with random stalls on both sides; %0d results, %0d matches.",
             result_count, match_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sfms_pkg.sv
rtl/sfms_if.sv
rtl/sfms_matcher.sv
rtl/substring_first_match_search.sv
bench/tb_substring_first_match_search.sv
